// ===== hw/rtl/u8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package u8sd_pkg;

  localparam int CP_W     = 21;
  localparam int IN_W     = 8;
  localparam int OUT_TD_W = 24;

  localparam logic [CP_W-1:0] BAD_CHAR = CP_W'(8'h3f);

  localparam logic [1:0] CONT_TAG = 2'b10;

  // Results caused by one input byte: up to three '?' and then an optional
  // final code point.
  typedef struct packed {
    logic [1:0]      bad_cnt;
    logic            has_final;
    logic [CP_W-1:0] final_cp;
  } u8sd_bundle_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder: one byte in per transfer, code points out.
// Depends on u8sd_pkg.
// Each byte's results are held in the output register, from which they are offered in turn.
// Throughput: one byte per cycle while each byte makes at most one result and
// the output is not stalled; a byte that makes more results (up to four, on an
// interrupted sequence) holds the input while the single output register drains them.
// Reset (rst, synchronous, active high): no sequence open, output register empty.
`default_nettype none

module utf8_stream_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [u8sd_pkg::IN_W-1:0]     s_tdata,  // [7:0] data_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [u8sd_pkg::OUT_TD_W-1:0]      m_tdata,  // [20:0] code_point, [23:21] zero
  output logic                               m_tlast   // last_in_run
);
  import u8sd_pkg::*;

  logic [CP_W-1:0] partial_value, partial_value_next;
  logic [1:0]      bytes_remaining, bytes_remaining_next;
  logic [1:0]      cont_taken, cont_taken_next;

  logic            bun_valid;
  u8sd_bundle_t    bun, bun_next;

  logic            in_xfer, out_xfer, cur_last;
  logic [IN_W-1:0] b;
  logic            seq_open, is_cont;

  assign b        = s_tdata;
  assign seq_open = (bytes_remaining != 2'd0);
  assign is_cont  = (b[7:6] == CONT_TAG);

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    cont_taken_next      = cont_taken;
    bun_next.bad_cnt     = 2'd0;
    bun_next.has_final   = 1'b0;
    bun_next.final_cp    = BAD_CHAR;
    if (seq_open && is_cont) begin
      partial_value_next   = {partial_value[CP_W-7:0], b[5:0]};
      bytes_remaining_next = bytes_remaining - 2'd1;
      cont_taken_next      = cont_taken + 2'd1;
      if (bytes_remaining == 2'd1) begin
        bun_next.has_final   = 1'b1;
        bun_next.final_cp    = {partial_value[CP_W-7:0], b[5:0]};
        partial_value_next   = '0;
        cont_taken_next      = 2'd0;
      end
    end else begin
      // interrupted sequence: '?' for the lead and each continuation taken
      if (seq_open) begin
        bun_next.bad_cnt = (cont_taken == 2'd3) ? 2'd3 : cont_taken + 2'd1;
      end
      partial_value_next   = '0;
      bytes_remaining_next = 2'd0;
      cont_taken_next      = 2'd0;
      if (b == '0) begin
        // end of text: nothing of its own
      end else if (!b[7]) begin
        bun_next.has_final = 1'b1;
        bun_next.final_cp  = CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
        partial_value_next   = CP_W'(b[4:0]);
        bytes_remaining_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_value_next   = CP_W'(b[3:0]);
        bytes_remaining_next = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial_value_next   = CP_W'(b[2:0]);
        bytes_remaining_next = 2'd3;
      end else begin
        bun_next.has_final = 1'b1;
      end
    end
  end

  // current output item: pending '?' first, then the final code point
  assign cur_last = (bun.bad_cnt == 2'd0) || ((bun.bad_cnt == 2'd1) && !bun.has_final);
  assign m_tvalid = bun_valid;
  assign m_tlast  = cur_last;
  assign m_tdata  = OUT_TD_W'((bun.bad_cnt != 2'd0) ? BAD_CHAR : bun.final_cp);

  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = !bun_valid || (m_tready && cur_last);
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= 2'd0;
      cont_taken      <= 2'd0;
      bun_valid       <= 1'b0;
    end else begin
      if (in_xfer) begin
        partial_value   <= partial_value_next;
        bytes_remaining <= bytes_remaining_next;
        cont_taken      <= cont_taken_next;
        bun_valid       <= (bun_next.bad_cnt != 2'd0) || bun_next.has_final;
      end else if (out_xfer && cur_last) begin
        bun_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bun <= bun_next;
    end else if (out_xfer && (bun.bad_cnt != 2'd0)) begin
      bun.bad_cnt <= bun.bad_cnt - 2'd1;
    end
  end

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (rst)
    bun_valid |-> ((bun.bad_cnt != 2'd0) || bun.has_final))
    else $error("output register holds an empty bundle");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  a_taken_only_in_seq: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining == 2'd0) |-> (cont_taken == 2'd0))
    else $error("continuation count set with no sequence open");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast && !in_xfer) |=> !m_tvalid)
    else $error("output still valid after last result drained");

  a_not_last_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !m_tlast) |=> m_tvalid)
    else $error("bundle dropped before its last result");

endmodule

`default_nettype wire
